// ===== design/nmea_sentence_checksum_framer_top_assert.svh =====
// ---------------------------------------------------------------------------
// NMEA sentence framer assertion macros
// Shorthand for the concurrent checks at the end of the framer top level.
// ---------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define NSCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define NSCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/nscf_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence framer package
// Types, framing characters and the hex digit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nscf_pkg;

   localparam int COUNT_WIDTH  = 8;
   localparam int LENGTH_WIDTH = 7;

   typedef logic [7:0]             byte_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [31:0]            total_type;
   typedef logic [4:0]             hex_type;

   localparam byte_type  START_MARK      = 8'h24;
   localparam byte_type  END_MARK        = 8'h0D;
   localparam count_type MIN_GOOD_LENGTH = 8'd6;
   localparam count_type KIND_POSITION   = 8'd3;
   localparam count_type XOR_FIRST_POS   = 8'd4;
   localparam hex_type   HEX_INVALID     = 5'd16;

   // Decode one ASCII hex digit, either case; HEX_INVALID for anything else.
   function automatic hex_type hex_value(input byte_type c);
      hex_type v;
      v = HEX_INVALID;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = hex_type'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = hex_type'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = hex_type'(c - 8'h57);
      end
      return v;
   endfunction

endpackage

// ===== design/nmea_sentence_checksum_framer_top.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence checksum framer
// Frames '$' ... CR sentences from a byte stream and checks the hex checksum.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle on req_ (while req_ready is high) and,
// for each sentence that ends in CR, gives one result item on rsp_:
// pass/fail, the computed XOR of the bytes after '$' up to the checksum
// marker (not checked to be '*'), the two-digit hex checksum received (0 if
// a digit is not hex), the byte at position 3, the length modulo 128, and the
// running pass and fail totals. Bytes outside a sentence give no item, and a
// sentence that reaches MAX_FRAME_BYTES bytes without a CR is dropped with no
// item. Throughput is one byte per clock while req_ready is high; a CR passes
// through the input register, then loads the result register that drives
// rsp_. req_ready drops only while a finished result waits in the result
// register and the byte in the input register is the CR of the next sentence.
`timescale 1ns / 1ps

`include "nmea_sentence_checksum_framer_top_assert.svh"

module nmea_sentence_checksum_framer_top
   import nscf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 91
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_checksum_ok,
   output logic [7:0]              rsp_computed_sum,
   output logic [7:0]              rsp_received_sum,
   output logic [7:0]              rsp_sentence_letter,
   output logic [LENGTH_WIDTH-1:0] rsp_frame_length,
   output logic [31:0]             rsp_pass_total,
   output logic [31:0]             rsp_fail_total
);

   localparam count_type MaxCount = count_type'(MAX_FRAME_BYTES);

   // Input register
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff,  in_byte_in;

   // Framer state
   logic      in_frame_ff,    in_frame_in;
   count_type byte_count_ff,  byte_count_in;
   byte_type  running_xor_ff, running_xor_in;
   byte_type  tail_ff [3];
   byte_type  tail_in [3];
   byte_type  kind_letter_ff, kind_letter_in;
   total_type pass_ff,        pass_in;
   total_type fail_ff,        fail_in;

   // Result register
   logic      rsp_valid_ff,   rsp_valid_in;
   logic      ok_ff,          ok_in;
   byte_type  comp_ff,        comp_in;
   byte_type  recv_ff,        recv_in;
   byte_type  letter_ff,      letter_in;
   logic [LENGTH_WIDTH-1:0] length_ff, length_in;
   total_type pass_out_ff,    pass_out_in;
   total_type fail_out_ff,    fail_out_in;

   logic      out_free;
   logic      is_end;
   logic      makes_result;
   logic      fire;
   count_type count_next;
   hex_type   hi_digit;
   hex_type   lo_digit;
   logic      digits_ok;
   byte_type  recv_value;
   logic      frame_ok;

   // Result slot frees when empty or being taken this cycle.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign is_end       = (in_byte_ff == END_MARK);
   assign makes_result = in_frame_ff && is_end;
   // Hold the staged byte only when it would overwrite a waiting result.
   assign fire         = in_valid_ff && (!makes_result || out_free);
   assign req_ready    = !in_valid_ff || fire;

   assign count_next = byte_count_ff + count_type'(1);
   assign hi_digit   = hex_value(tail_ff[1]);
   assign lo_digit   = hex_value(tail_ff[2]);
   assign digits_ok  = !hi_digit[4] && !lo_digit[4];
   assign recv_value = digits_ok ? {hi_digit[3:0], lo_digit[3:0]} : 8'h00;
   assign frame_ok   = digits_ok && (count_next >= MIN_GOOD_LENGTH) &&
                       (recv_value == running_xor_ff);

   // Stage the incoming byte.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Advance the framer on the staged byte.
   always_comb begin
      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      tail_in        = tail_ff;
      kind_letter_in = kind_letter_ff;
      pass_in        = pass_ff;
      fail_in        = fail_ff;
      if (fire) begin
         if (!in_frame_ff) begin
            // Hunt: open a frame on '$', drop everything else.
            if (in_byte_ff == START_MARK) begin
               in_frame_in    = 1'b1;
               byte_count_in  = count_type'(1);
               running_xor_in = 8'h00;
               tail_in        = '{8'h00, 8'h00, 8'h00};
               kind_letter_in = 8'h00;
            end
         end else begin
            byte_count_in = count_next;
            if (is_end) begin
               in_frame_in = 1'b0;
               if (frame_ok) begin
                  pass_in = pass_ff + 32'd1;
               end else begin
                  fail_in = fail_ff + 32'd1;
               end
            end else begin
               if (byte_count_ff == KIND_POSITION) begin
                  kind_letter_in = in_byte_ff;
               end
               // Fold the oldest tail byte once it can no longer be checksum text.
               if (byte_count_ff >= XOR_FIRST_POS) begin
                  running_xor_in = running_xor_ff ^ tail_ff[0];
               end
               tail_in[0] = tail_ff[1];
               tail_in[1] = tail_ff[2];
               tail_in[2] = in_byte_ff;
               // Drop an overlong frame.
               if (count_next >= MaxCount) begin
                  in_frame_in = 1'b0;
               end
            end
         end
      end
   end

   // Load the result register on CR, clear it when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      comp_in      = comp_ff;
      recv_in      = recv_ff;
      letter_in    = letter_ff;
      length_in    = length_ff;
      pass_out_in  = pass_out_ff;
      fail_out_in  = fail_out_ff;
      if (fire && makes_result) begin
         rsp_valid_in = 1'b1;
         ok_in        = frame_ok;
         comp_in      = running_xor_ff;
         recv_in      = recv_value;
         letter_in    = kind_letter_ff;
         length_in    = count_next[LENGTH_WIDTH-1:0];
         pass_out_in  = pass_in;
         fail_out_in  = fail_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_xor_ff <= '0;
         tail_ff        <= '{8'h00, 8'h00, 8'h00};
         kind_letter_ff <= '0;
         pass_ff        <= '0;
         fail_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_xor_ff <= running_xor_in;
         tail_ff        <= tail_in;
         kind_letter_ff <= kind_letter_in;
         pass_ff        <= pass_in;
         fail_ff        <= fail_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      ok_ff       <= ok_in;
      comp_ff     <= comp_in;
      recv_ff     <= recv_in;
      letter_ff   <= letter_in;
      length_ff   <= length_in;
      pass_out_ff <= pass_out_in;
      fail_out_ff <= fail_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_checksum_ok     = ok_ff;
   assign rsp_computed_sum    = comp_ff;
   assign rsp_received_sum    = recv_ff;
   assign rsp_sentence_letter = letter_ff;
   assign rsp_frame_length    = length_ff;
   assign rsp_pass_total      = pass_out_ff;
   assign rsp_fail_total      = fail_out_ff;

   // A passing result always carries matching sums.
   `NSCF_ASSERT_NOW(a_pass_sums_match, clock, reset,
      rsp_valid && rsp_checksum_ok, rsp_received_sum == rsp_computed_sum,
      "passing item with mismatched sums")
   // Each closed frame bumps exactly one of the two totals.
   `NSCF_ASSERT_NEXT(a_one_total_step, clock, reset,
      fire && makes_result,
      32'(pass_ff + fail_ff) == 32'($past(pass_ff + fail_ff) + 32'd1),
      "closed frame did not advance exactly one total")
   // An open frame never holds the limit count.
   `NSCF_ASSERT_NOW(a_count_in_range, clock, reset,
      in_frame_ff, byte_count_ff < MaxCount,
      "open frame at or past the length limit")

endmodule

// ===== test/nscf_sentence_checker.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence framer checker
// Watches both channels, predicts each sentence result, compares on arrival.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nscf_sentence_checker
   import nscf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 91
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_checksum_ok,
   input  logic [7:0]              rsp_computed_sum,
   input  logic [7:0]              rsp_received_sum,
   input  logic [7:0]              rsp_sentence_letter,
   input  logic [LENGTH_WIDTH-1:0] rsp_frame_length,
   input  logic [31:0]             rsp_pass_total,
   input  logic [31:0]             rsp_fail_total,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      verdict_count,
   output int                      dropped_count
);

   typedef struct {
      logic                    ok;
      logic [7:0]              computed;
      logic [7:0]              received;
      logic [7:0]              letter;
      logic [LENGTH_WIDTH-1:0] length;
      logic [31:0]             passes;
      logic [31:0]             fails;
   } sentence_verdict_type;

   sentence_verdict_type verdict_q[$];

   // framer state as the block should hold it
   bit          framing = 1'b0;
   int          seen    = 0;
   logic [7:0]  xor_sum = '0;
   logic [7:0]  tail [3] = '{default: '0};
   logic [7:0]  letter  = '0;
   logic [31:0] passes  = '0;
   logic [31:0] fails   = '0;
   int          errors  = 0;
   int          checked = 0;
   int          dropped = 0;

   // 0..15 for a hex digit of either case, 16 otherwise
   function automatic int digit_value(input logic [7:0] c);
      int v;
      v = 16;
      if (c inside {[8'h30:8'h39]}) begin
         v = int'(c) - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = int'(c) - 8'h41 + 10;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = int'(c) - 8'h61 + 10;
      end
      return v;
   endfunction

   function automatic void clear_framer();
      framing = 1'b0;
      seen    = 0;
      xor_sum = '0;
      tail    = '{default: '0};
      letter  = '0;
   endfunction

   // advance the framer by one accepted byte; queue a verdict on CR
   function automatic void frame_byte(input logic [7:0] b);
      int                   pos;
      int                   hi;
      int                   lo;
      bit                   digits_ok;
      logic [7:0]           recv;
      bit                   ok;
      sentence_verdict_type v;
      if (!framing) begin
         if (b == START_MARK) begin
            clear_framer();
            framing = 1'b1;
            seen    = 1;
         end
      end else begin
         pos  = seen;
         seen = seen + 1;
         if (b == END_MARK) begin
            hi        = digit_value(tail[1]);
            lo        = digit_value(tail[2]);
            digits_ok = (hi < 16) && (lo < 16);
            recv      = digits_ok ? 8'((hi << 4) | lo) : 8'h00;
            ok        = digits_ok && (seen >= MIN_GOOD_LENGTH) && (recv == xor_sum);
            if (ok) begin
               passes = passes + 1;
            end else begin
               fails = fails + 1;
            end
            v.ok       = ok;
            v.computed = xor_sum;
            v.received = recv;
            v.letter   = letter;
            v.length   = LENGTH_WIDTH'(seen);
            v.passes   = passes;
            v.fails    = fails;
            verdict_q.push_back(v);
            framing = 1'b0;
         end else begin
            if (pos == KIND_POSITION) begin
               letter = b;
            end
            if (pos >= XOR_FIRST_POS) begin
               xor_sum = xor_sum ^ tail[0];
            end
            tail[0] = tail[1];
            tail[1] = tail[2];
            tail[2] = b;
            if (seen >= MAX_FRAME_BYTES) begin
               framing = 1'b0;
               dropped = dropped + 1;
            end
         end
      end
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors = errors + 1;
      end
   endfunction

   always @(posedge clock) begin : watch
      sentence_verdict_type want;
      if (reset) begin
         clear_framer();
         passes = '0;
         fails  = '0;
         verdict_q.delete();
      end else begin
         // compare first: a result never belongs to a CR taken at this same edge
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("result item with no sentence waiting");
               errors = errors + 1;
            end else begin
               want    = verdict_q.pop_front();
               checked = checked + 1;
               check_field("checksum_ok", 32'(want.ok), 32'(rsp_checksum_ok));
               check_field("computed_sum", 32'(want.computed), 32'(rsp_computed_sum));
               check_field("received_sum", 32'(want.received), 32'(rsp_received_sum));
               check_field("sentence_letter", 32'(want.letter),
                           32'(rsp_sentence_letter));
               check_field("frame_length", 32'(want.length), 32'(rsp_frame_length));
               check_field("pass_total", want.passes, rsp_pass_total);
               check_field("fail_total", want.fails, rsp_fail_total);
            end
         end
         if (req_valid && req_ready) begin
            frame_byte(req_rx_byte);
         end
      end
      mismatch_count <= errors;
      pending_count  <= verdict_q.size();
      verdict_count  <= checked;
      dropped_count  <= dropped;
   end

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// NMEA sentence framer testbench
// Streams sentences, noise and broken frames through the framer under random
// sender bursts and receiver stalls; a checker module grades every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import nscf_pkg::*;

   localparam int  MAX_BYTES   = 91;
   localparam int  BYTE_TARGET = 1700;
   localparam int  DRAIN_WAIT  = 10;
   localparam time LIMIT_NS    = 4ms;

   localparam byte_type CHAR_ZERO    = 8'h30;
   localparam byte_type CHAR_UPPER_A = 8'h41;
   localparam byte_type CHAR_LOWER_A = 8'h61;
   localparam byte_type CHAR_STAR    = 8'h2A;

   typedef enum int {
      SENTENCE_GOOD,
      SENTENCE_BAD_SUM,
      SENTENCE_BAD_HEX,
      SENTENCE_NO_STAR
   } sentence_kind_type;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_MOSTLY,
      DRAIN_STARVED,
      DRAIN_PERIODIC
   } drain_mode_type;

   // Opening sequence: hunting byte, bare "$CR", short frame whose digits
   // match (still fails), lower case digits, '$' as payload, bad hex digit,
   // and a marker other than '*'.
   localparam byte_type OPENING [33] = '{
      8'h00,
      START_MARK, END_MARK,
      START_MARK, "*", "0", "0", END_MARK,
      START_MARK, "Z", "*", "5", "a", END_MARK,
      START_MARK, "$", "*", "2", "4", END_MARK,
      START_MARK, "Z", "*", "5", "G", END_MARK,
      START_MARK, "A", "F", "+", "0", "7", END_MARK
   };

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic [7:0]              req_rx_byte = 8'h00;
   logic                    rsp_ready   = 1'b0;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    rsp_checksum_ok;
   logic [7:0]              rsp_computed_sum;
   logic [7:0]              rsp_received_sum;
   logic [7:0]              rsp_sentence_letter;
   logic [LENGTH_WIDTH-1:0] rsp_frame_length;
   logic [31:0]             rsp_pass_total;
   logic [31:0]             rsp_fail_total;

   int mismatch_count;
   int pending_count;
   int verdict_count;
   int dropped_count;

   int             burst_left   = 0;
   int             framed_bytes = 0;
   int             drain_left   = 0;
   drain_mode_type drain_mode   = DRAIN_FREE;

   nmea_sentence_checksum_framer_top #(
      .MAX_FRAME_BYTES(MAX_BYTES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_computed_sum   (rsp_computed_sum),
      .rsp_received_sum   (rsp_received_sum),
      .rsp_sentence_letter(rsp_sentence_letter),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_pass_total     (rsp_pass_total),
      .rsp_fail_total     (rsp_fail_total)
   );

   // Grade every result against the predicted sentence verdicts.
   nscf_sentence_checker #(
      .MAX_FRAME_BYTES(MAX_BYTES)
   ) u_sentence_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_computed_sum   (rsp_computed_sum),
      .rsp_received_sum   (rsp_received_sum),
      .rsp_sentence_letter(rsp_sentence_letter),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_pass_total     (rsp_pass_total),
      .rsp_fail_total     (rsp_fail_total),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .verdict_count      (verdict_count),
      .dropped_count      (dropped_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #(LIMIT_NS);
      $display("tb_top: errors");
      $finish;
   end

   // Receiver: pick a stall mode for a random stretch, then move on.
   always @(negedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_left = $urandom_range(16, 160);
      end
      drain_left = drain_left - 1;
      case (drain_mode)
         DRAIN_FREE: begin
            rsp_ready <= 1'b1;
         end
         DRAIN_MOSTLY: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         DRAIN_STARVED: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            // long low stretch, short high window
            rsp_ready <= ((drain_left % 12) < 3);
         end
      endcase
   end

   // Offer one byte and hold it until the framer takes it. Between bursts,
   // drop valid for a random gap; many bursts start with no gap at all.
   task automatic push_byte(input byte_type b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      burst_left = burst_left - 1;
   endtask

   // Any byte but CR; mostly printable so sentences look like sentences.
   function automatic byte_type payload_byte();
      byte_type b;
      if ($urandom_range(0, 3) != 0) begin
         b = byte_type'($urandom_range(8'h20, 8'h7E));
      end else begin
         do b = byte_type'($urandom); while (b == END_MARK);
      end
      return b;
   endfunction

   function automatic byte_type hex_char(input logic [3:0] nibble, input bit lower);
      byte_type c;
      if (nibble < 4'd10) begin
         c = CHAR_ZERO + byte_type'(nibble);
      end else begin
         c = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + byte_type'(nibble - 4'd10);
      end
      return c;
   endfunction

   // Pick from ranges that hold no hex digit and no CR.
   function automatic byte_type non_hex_char();
      byte_type c;
      case ($urandom_range(0, 2))
         0:       c = byte_type'($urandom_range(8'h67, 8'hFF));
         1:       c = byte_type'($urandom_range(8'h47, 8'h60));
         default: c = byte_type'($urandom_range(8'h0E, 8'h2F));
      endcase
      return c;
   endfunction

   // Send '$', body, marker, two digits, CR; the kind decides what is broken.
   task automatic send_sentence(input int body_len, input sentence_kind_type kind);
      byte_type sum;
      byte_type b;
      byte_type hi_c;
      byte_type lo_c;
      byte_type star;
      int       pick;
      sum = '0;
      push_byte(START_MARK);
      for (int i = 0; i < body_len; i++) begin
         b   = payload_byte();
         sum = sum ^ b;
         push_byte(b);
      end
      star = CHAR_STAR;
      if (kind == SENTENCE_NO_STAR) begin
         star = payload_byte();
      end
      if (kind == SENTENCE_BAD_SUM) begin
         sum = sum ^ byte_type'($urandom_range(1, 255));
      end
      hi_c = hex_char(sum[7:4], 1'($urandom_range(0, 1)));
      lo_c = hex_char(sum[3:0], 1'($urandom_range(0, 1)));
      if (kind == SENTENCE_BAD_HEX) begin
         pick = $urandom_range(0, 2);
         if (pick != 1) hi_c = non_hex_char();
         if (pick != 0) lo_c = non_hex_char();
      end
      push_byte(star);
      push_byte(hi_c);
      push_byte(lo_c);
      push_byte(END_MARK);
      framed_bytes = framed_bytes + body_len + 5;
   endtask

   // Frame shorter than six bytes; digit slots may or may not be filled.
   task automatic send_short();
      int n;
      n = $urandom_range(0, 3);
      push_byte(START_MARK);
      for (int i = 0; i < n; i++) begin
         push_byte(($urandom_range(0, 1) == 0) ?
                   hex_char(4'($urandom), 1'($urandom_range(0, 1))) : payload_byte());
      end
      push_byte(END_MARK);
      framed_bytes = framed_bytes + n + 2;
   endtask

   // Line noise: any byte, now and then a stray '$' that opens a frame.
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(byte_type'($urandom));
      end
   endtask

   initial begin : stimulus
      int                pick;
      int                body;
      sentence_kind_type kind;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short directed opening
      for (int i = 0; i < $size(OPENING); i++) begin
         push_byte(OPENING[i]);
      end

      // length limit: CR as the last allowed byte, then one byte too many
      send_sentence(MAX_BYTES - 5, SENTENCE_GOOD);
      send_sentence(MAX_BYTES - 4, SENTENCE_GOOD);

      // random traffic: mostly well-formed sentences with random content
      while (framed_bytes < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_noise($urandom_range(1, 6));
         end else if (pick < 14) begin
            send_short();
         end else begin
            body = ($urandom_range(0, 19) == 0) ? $urandom_range(40, MAX_BYTES - 4)
                                                : $urandom_range(1, 18);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               kind = SENTENCE_GOOD;
            end else begin
               kind = sentence_kind_type'(pick - 6);
            end
            send_sentence(body, kind);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: wait for every predicted result, then let DRAIN_WAIT pass before the final check
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (pending_count != 0) begin
         $error("%0d sentence results never arrived", pending_count);
      end
      $display("Run covered %0d framed bytes plus noise, %0d sentence results checked,",
               framed_bytes, verdict_count);
      $display("and %0d overlong frames dropped without a result.", dropped_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/nscf_pkg.sv
design/nmea_sentence_checksum_framer_top.sv
test/nscf_sentence_checker.sv
test/tb_top.sv
